>>> rtl/b64sc_pkg.sv
`timescale 1ns / 1ps
package b64sc_pkg;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   localparam int unsigned IDX_W  = 6;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CNT_W  = 3;

   // one result item as it sits in the output buffer
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              valid;
      logic              last;
   } res_type;

   // output buffer status toward the input stage
   typedef struct packed {
      logic load_ok;
      logic two_held;
   } obuf_status_type;

   // 6-bit index to standard alphabet character
   function automatic logic [BYTE_W-1:0] index_to_char(input logic [IDX_W-1:0] idx);
      logic [BYTE_W-1:0] ch;
      logic [BYTE_W-1:0] wide;
      wide = {2'b00, idx};
      if (idx < 6'd26) begin
         ch = 8'h41 + wide;
      end else if (idx < 6'd52) begin
         ch = 8'h61 + wide - 8'd26;
      end else if (idx < 6'd62) begin
         ch = 8'h30 + wide - 8'd52;
      end else if (idx == 6'd62) begin
         ch = 8'h2B;
      end else begin
         ch = 8'h2F;
      end
      return ch;
   endfunction

   // alphabet character to 6-bit index, anything else maps to 63
   function automatic logic [IDX_W-1:0] char_to_index(input logic [BYTE_W-1:0] ch);
      logic [BYTE_W-1:0] wide;
      wide = 8'd63;
      if (ch >= 8'h41 && ch <= 8'h5A) begin
         wide = ch - 8'h41;
      end else if (ch >= 8'h61 && ch <= 8'h7A) begin
         wide = ch - 8'h61 + 8'd26;
      end else if (ch >= 8'h30 && ch <= 8'h39) begin
         wide = ch - 8'h30 + 8'd52;
      end else if (ch == 8'h2B) begin
         wide = 8'd62;
      end
      return wide[IDX_W-1:0];
   endfunction

endpackage

>>> rtl/base64_stream_codec_top.sv
`timescale 1ns / 1ps
// streaming base64 codec, one byte or character per input item
// req channel: req_in_byte with req_in_last marking the end of a message,
//   taken on req_valid && req_ready
// rsp channel: rsp_out_byte, rsp_out_valid (clear on a bare end marker),
//   rsp_out_last on the final item of a message, taken on rsp_valid && rsp_ready
// csr port: csr_wr_en writes csr_wr_data as the mode (0 encode, 1 decode)
//   and drops any leftover bits; write only while the block is idle
// datapath: an item is registered in the input register, then its results
//   land in a two-entry result buffer whose head drives the rsp port
// throughput: while rsp_ready is high, one item per cycle when it gives at
//   most one result; after an item that gives two, the next waits for a drain;
//   the buffer drains one item per cycle via the rsp port and sets the pace
// reset: mode goes to encode, leftover bits clear, both stages empty
// stall: with rsp_ready low the buffer holds its items; the input register
//   still takes one more item, then req_ready drops until room opens
module base64_stream_codec_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_valid,
   output logic        rsp_out_last,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);
   import b64sc_pkg::*;

   // configuration and carried bit state
   logic              mode_ff, mode_in;
   logic [IDX_W-1:0]  holder_ff, holder_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // input register
   logic              a_valid_ff, a_valid_in;
   logic [BYTE_W-1:0] a_byte_ff, a_byte_in;
   logic              a_last_ff, a_last_in;

   // conversion results
   logic [1:0]        res_cnt;
   res_type           res0;
   res_type           res1;
   logic [IDX_W-1:0]  holder_next;
   logic [CNT_W-1:0]  count_next;

   obuf_status_type   obuf_status;
   res_type           rsp_res;
   logic              advance;
   logic              req_take;

   // item moves from the input register into the result buffer
   assign advance   = a_valid_ff && obuf_status.load_ok;
   assign req_ready = !a_valid_ff || obuf_status.load_ok;
   assign req_take  = req_valid && req_ready;

   b64sc_convert u_convert (
      .mode        (mode_ff),
      .holder      (holder_ff),
      .count       (count_ff),
      .in_byte     (a_byte_ff),
      .in_last     (a_last_ff),
      .res_cnt     (res_cnt),
      .res0        (res0),
      .res1        (res1),
      .holder_next (holder_next),
      .count_next  (count_next)
   );

   b64sc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .res_cnt   (res_cnt),
      .res0      (res0),
      .res1      (res1),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_res   (rsp_res),
      .status    (obuf_status)
   );

   assign rsp_out_byte  = rsp_res.data;
   assign rsp_out_valid = rsp_res.valid;
   assign rsp_out_last  = rsp_res.last;

   always_comb begin
      mode_in    = mode_ff;
      holder_in  = holder_ff;
      count_in   = count_ff;
      a_valid_in = a_valid_ff;
      a_byte_in  = a_byte_ff;
      a_last_in  = a_last_ff;
      // a mode write wins and drops leftover bits
      if (csr_wr_en) begin
         mode_in   = csr_wr_data;
         holder_in = '0;
         count_in  = '0;
      end else if (advance) begin
         holder_in = holder_next;
         count_in  = count_next;
      end
      if (req_take) begin
         a_valid_in = 1'b1;
         a_byte_in  = req_in_byte;
         a_last_in  = req_in_last;
      end else if (advance) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_ENCODE;
         holder_ff  <= '0;
         count_ff   <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         holder_ff  <= holder_in;
         count_ff   <= count_in;
         a_valid_ff <= a_valid_in;
      end
      a_byte_ff <= a_byte_in;
      a_last_ff <= a_last_in;
   end

   a_end_clears_bits: assert property (@(posedge clock) disable iff (reset)
      advance && a_last_ff |=> count_ff == '0 && holder_ff == '0)
      else $error("bits left over after end of message");

   a_csr_clears_bits: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> count_ff == '0 && holder_ff == '0)
      else $error("mode write did not drop leftover bits");

   a_bare_marker_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_valid |-> rsp_out_last)
      else $error("empty result item without end mark");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      advance |=> count_ff <= 3'd6)
      else $error("carried bit count out of range");

endmodule

>>> rtl/b64sc_convert.sv
`timescale 1ns / 1ps
module b64sc_convert (
   input  logic                          mode,
   input  logic [b64sc_pkg::IDX_W-1:0]   holder,
   input  logic [b64sc_pkg::CNT_W-1:0]   count,
   input  logic [b64sc_pkg::BYTE_W-1:0]  in_byte,
   input  logic                          in_last,
   output logic [1:0]                    res_cnt,
   output b64sc_pkg::res_type            res0,
   output b64sc_pkg::res_type            res1,
   output logic [b64sc_pkg::IDX_W-1:0]   holder_next,
   output logic [b64sc_pkg::CNT_W-1:0]   count_next
);
   import b64sc_pkg::*;

   logic [13:0]       enc_acc;
   logic [11:0]       dec_acc;
   logic [3:0]        total;
   logic [3:0]        rem;
   logic [2:0]        keep;
   logic [6:0]        mask;
   logic [IDX_W-1:0]  kept;
   logic [IDX_W-1:0]  pad_idx;
   logic [13:0]       sh0;
   logic [13:0]       sh1;
   logic [11:0]       dsh;
   logic [1:0]        n;
   res_type           r0;
   res_type           r1;

   always_comb begin
      enc_acc = {holder, in_byte};
      dec_acc = {holder, char_to_index(in_byte)};
      r0      = '0;
      r1      = '0;
      n       = 2'd0;
      sh0     = '0;
      sh1     = '0;
      dsh     = '0;
      if (mode == MODE_ENCODE) begin
         total = {1'b0, count} + 4'd8;
         sh0   = enc_acc >> (total - 4'd6);
         r0    = '{data: index_to_char(sh0[IDX_W-1:0]), valid: 1'b1, last: 1'b0};
         n     = 2'd1;
         if (total >= 4'd12) begin
            sh1 = enc_acc >> (total - 4'd12);
            r1  = '{data: index_to_char(sh1[IDX_W-1:0]), valid: 1'b1, last: 1'b0};
            n   = 2'd2;
            rem = total - 4'd12;
         end else begin
            rem = total - 4'd6;
         end
      end else begin
         total = {1'b0, count} + 4'd6;
         if (total >= 4'd8) begin
            dsh = dec_acc >> (total - 4'd8);
            r0  = '{data: dsh[BYTE_W-1:0], valid: 1'b1, last: 1'b0};
            n   = 2'd1;
            rem = total - 4'd8;
         end else begin
            rem = total;
         end
      end
      keep = (rem > 4'd6) ? 3'd6 : rem[2:0];
      mask = (7'd1 << keep) - 7'd1;
      kept = (mode == MODE_ENCODE) ? (enc_acc[IDX_W-1:0] & mask[IDX_W-1:0])
                                   : (dec_acc[IDX_W-1:0] & mask[IDX_W-1:0]);
      pad_idx = kept << (3'd6 - keep);

      holder_next = kept;
      count_next  = keep;
      if (in_last) begin
         // trailing encode bits go out zero-padded as one more character
         if (mode == MODE_ENCODE && keep != 3'd0 && n == 2'd1) begin
            r1 = '{data: index_to_char(pad_idx), valid: 1'b1, last: 1'b0};
            n  = 2'd2;
         end
         case (n)
            2'd0: begin
               r0 = '{data: '0, valid: 1'b0, last: 1'b1};
               n  = 2'd1;
            end
            2'd1: r0.last = 1'b1;
            default: r1.last = 1'b1;
         endcase
         holder_next = '0;
         count_next  = '0;
      end
   end

   assign res_cnt = n;
   assign res0    = r0;
   assign res1    = r1;

endmodule

>>> rtl/b64sc_out_buf.sv
`timescale 1ns / 1ps
module b64sc_out_buf (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  logic [1:0]                  res_cnt,
   input  b64sc_pkg::res_type          res0,
   input  b64sc_pkg::res_type          res1,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output b64sc_pkg::res_type          rsp_res,
   output b64sc_pkg::obuf_status_type  status
);
   import b64sc_pkg::*;

   logic [1:0] cnt_ff, cnt_in;
   res_type    ent0_ff, ent0_in;
   res_type    ent1_ff, ent1_in;
   logic       pop;

   assign rsp_valid       = cnt_ff != 2'd0;
   assign rsp_res         = ent0_ff;
   assign pop             = rsp_valid && rsp_ready;
   assign status.load_ok  = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_ready);
   assign status.two_held = cnt_ff == 2'd2;

   always_comb begin
      cnt_in  = cnt_ff;
      ent0_in = ent0_ff;
      ent1_in = ent1_ff;
      if (load) begin
         cnt_in  = res_cnt;
         ent0_in = res0;
         ent1_in = res1;
      end else if (pop) begin
         if (cnt_ff == 2'd2) begin
            ent0_in = ent1_ff;
            cnt_in  = 2'd1;
         end else begin
            cnt_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      ent0_ff <= ent0_in;
      ent1_ff <= ent1_in;
   end

   a_no_load_over_pair: assert property (@(posedge clock) disable iff (reset)
      load |-> !status.two_held)
      else $error("result buffer loaded while holding two items");

   a_pair_drains_to_one: assert property (@(posedge clock) disable iff (reset)
      status.two_held && rsp_ready |=> cnt_ff == 2'd1)
      else $error("pair in result buffer did not drain to one item");

   a_second_moves_up: assert property (@(posedge clock) disable iff (reset)
      status.two_held && rsp_ready |=> rsp_res == $past(ent1_ff))
      else $error("second buffered item not moved to head");

endmodule
